@@ src/vdp_pkg.sv @@
// Shared types, codes and constants of the vertex delta pack decoder.
`default_nettype none
package vdp_pkg;

  localparam int MAX_ENTRIES_DEF    = 4096;
  localparam int MAX_COMPONENTS_DEF = 3;
  localparam int CPE_W              = 2;
  localparam int CNT_W              = 13;
  localparam int CFG_W              = 13;
  localparam int CFG_IDX_W          = 2;
  localparam int QUEUE_DEPTH        = 2;
  localparam logic [7:0]  SCALE_LIMIT = 8'd30;
  localparam logic [31:0] BIAS_BYTE   = 32'd127;
  localparam logic [31:0] BIAS_HALF   = 32'd32767;
  localparam logic [31:0] QNAN_BIT    = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPE      = 2'd0,
    CFG_COUNT    = 2'd1,
    CFG_INT_MODE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_FLAGS  = 2'd0,
    PH_SCALE  = 2'd1,
    PH_VALUES = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    WC_ZERO = 2'd0,
    WC_BYTE = 2'd1,
    WC_HALF = 2'd2,
    WC_WORD = 2'd3
  } width_code_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] value_bits;
    logic [1:0]  component;
    logic [11:0] entry_index;
    logic        last;
    logic        order_error;
  } out_word_t;

  // front to back command
  typedef struct packed {
    logic        err;
    width_code_t code;
    logic [31:0] raw;
    logic [4:0]  shift;
    logic [1:0]  comp;
    logic [11:0] entry;
    logic        last;
  } cmd_t;

endpackage
`default_nettype wire

@@ src/vdp_queue.sv @@
// Short command queue between the front and the back.
`default_nettype none
module vdp_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  vdp_pkg::cmd_t    push_cmd,
  output logic             full,
  input  wire logic        pop,
  output vdp_pkg::cmd_t    head,
  output logic             not_empty
);
  localparam int PW = (vdp_pkg::QUEUE_DEPTH > 1) ? $clog2(vdp_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(vdp_pkg::QUEUE_DEPTH + 1);

  vdp_pkg::cmd_t slots [vdp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(vdp_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    bump = (p == PW'(vdp_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop) rd_ptr <= bump(rd_ptr);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end
endmodule
`default_nettype wire

@@ src/vdp_front.sv @@
// Front: parses flags, scale and value bytes and issues commands.
`default_nettype none
module vdp_front #(
  parameter int MAX_ENTRIES    = vdp_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_COMPONENTS = vdp_pkg::MAX_COMPONENTS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    byte_valid,
  output logic                         byte_stall,
  input  vdp_pkg::in_word_t            byte_word,
  input  wire logic [vdp_pkg::CPE_W-1:0] cpe,
  input  wire logic [vdp_pkg::CNT_W-1:0] entry_count,
  output logic                         cmd_push,
  output vdp_pkg::cmd_t                cmd,
  input  wire logic                    cmd_full
);
  localparam int TOTAL      = MAX_ENTRIES * MAX_COMPONENTS;
  localparam int FLAG_DEPTH = (TOTAL + 3) / 4;
  localparam int FLAG_AW    = (FLAG_DEPTH > 1) ? $clog2(FLAG_DEPTH) : 1;
  localparam int POS_W      = FLAG_AW + 2;
  localparam int TOT_W      = POS_W + 1;
  localparam int REC_SH     = POS_W + 1;
  localparam int RECIP      = ((1 << REC_SH) + 2) / 3;
  localparam int PROD_W     = 2 * POS_W + 1;

  logic [7:0] flag_mem [FLAG_DEPTH];
  logic [7:0] flag_rd;

  vdp_pkg::phase_t phase, phase_next;
  logic [FLAG_AW-1:0] flag_cnt, flag_cnt_next;
  logic [4:0]  scale, scale_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [31:0] asm_word, asm_word_next;
  logic [1:0]  gathered, gathered_next;

  logic take, mem_we;
  logic [vdp_pkg::CPE_W-1:0] cpe_e;
  logic [vdp_pkg::CNT_W-1:0] cnt_e;
  logic [vdp_pkg::CNT_W+1:0] tot_raw;
  logic [TOT_W-1:0] total, needed, cnt_inc, pos_inc;
  logic is_last;
  logic [PROD_W-1:0] prod;
  logic [POS_W-1:0] q3, entry_pos, rem;
  logic [1:0] comp;
  vdp_pkg::width_code_t code;
  logic [2:0] need, g_inc;
  logic [31:0] asm_new;
  logic [7:0] b;

  // effective configuration
  always_comb begin
    if (cpe == '0) cpe_e = vdp_pkg::CPE_W'(1);
    else if (32'(cpe) > MAX_COMPONENTS) cpe_e = vdp_pkg::CPE_W'(MAX_COMPONENTS);
    else cpe_e = cpe;
    if (entry_count == '0) cnt_e = vdp_pkg::CNT_W'(1);
    else if (32'(entry_count) > MAX_ENTRIES) cnt_e = vdp_pkg::CNT_W'(MAX_ENTRIES);
    else cnt_e = entry_count;
    tot_raw = (vdp_pkg::CNT_W+2)'(cpe_e) * (vdp_pkg::CNT_W+2)'(cnt_e);
    total   = TOT_W'(tot_raw);
    needed  = (total + TOT_W'(3)) >> 2;
    cnt_inc = TOT_W'(flag_cnt) + TOT_W'(1);
    pos_inc = TOT_W'(pos) + TOT_W'(1);
    is_last = (pos_inc >= total);
  end

  // entry and component of the current position; divide by three via reciprocal
  always_comb begin
    prod = PROD_W'(pos) * PROD_W'(RECIP);
    q3   = prod[PROD_W-1:REC_SH];
    case (cpe_e)
      2'd1:    entry_pos = pos;
      2'd2:    entry_pos = pos >> 1;
      default: entry_pos = q3;
    endcase
    rem  = pos - POS_W'((POS_W+2)'(entry_pos) * (POS_W+2)'(cpe_e));
    comp = rem[1:0];
  end

  assign b    = byte_word.data_byte;
  assign code = vdp_pkg::width_code_t'(flag_rd[{pos[1:0], 1'b0} +: 2]);

  always_comb begin
    unique case (code)
      vdp_pkg::WC_BYTE: need = 3'd1;
      vdp_pkg::WC_HALF: need = 3'd2;
      default:          need = 3'd4;
    endcase
    g_inc   = {1'b0, gathered} + 3'd1;
    asm_new = asm_word | (32'(b) << {gathered, 3'b000});
  end

  assign byte_stall = cmd_full;
  assign take       = byte_valid && !cmd_full;

  always_comb begin
    phase_next    = phase;
    flag_cnt_next = flag_cnt;
    scale_next    = scale;
    pos_next      = pos;
    asm_word_next = asm_word;
    gathered_next = gathered;
    mem_we        = 1'b0;
    cmd_push      = 1'b0;
    cmd.err       = 1'b0;
    cmd.code      = code;
    cmd.raw       = asm_new;
    cmd.shift     = scale;
    cmd.comp      = comp;
    cmd.entry     = 12'(entry_pos);
    cmd.last      = is_last;
    if (take) begin
      unique case (phase)
        vdp_pkg::PH_FLAGS: begin
          if (!byte_word.op) begin
            mem_we = 1'b1;
            if (cnt_inc >= needed) begin
              phase_next    = vdp_pkg::PH_SCALE;
              flag_cnt_next = '0;
            end else begin
              flag_cnt_next = FLAG_AW'(cnt_inc);
            end
          end
        end
        vdp_pkg::PH_SCALE: begin
          if (!byte_word.op) begin
            scale_next    = (b > vdp_pkg::SCALE_LIMIT) ? vdp_pkg::SCALE_LIMIT[4:0] : b[4:0];
            phase_next    = vdp_pkg::PH_VALUES;
            pos_next      = '0;
            asm_word_next = '0;
            gathered_next = '0;
          end
        end
        vdp_pkg::PH_VALUES: begin
          if (byte_word.op) begin
            if (code == vdp_pkg::WC_ZERO) begin
              cmd_push = 1'b1;
              cmd.raw  = '0;
            end
          end else if (code == vdp_pkg::WC_ZERO) begin
            // byte while a zero component waits: dropped and flagged
            cmd_push = 1'b1;
            cmd.err  = 1'b1;
            cmd.raw  = '0;
            cmd.last = 1'b0;
          end else if (g_inc >= need) begin
            cmd_push = 1'b1;
          end else begin
            asm_word_next = asm_new;
            gathered_next = g_inc[1:0];
          end
          if (cmd_push && !cmd.err) begin
            asm_word_next = '0;
            gathered_next = '0;
            if (is_last) begin
              phase_next    = vdp_pkg::PH_FLAGS;
              flag_cnt_next = '0;
              pos_next      = '0;
            end else begin
              pos_next = POS_W'(pos_inc);
            end
          end
        end
        default: begin
          phase_next = vdp_pkg::PH_FLAGS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) flag_mem[flag_cnt] <= b;
    flag_rd <= flag_mem[pos_next[POS_W-1:2]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= vdp_pkg::PH_FLAGS;
      flag_cnt <= '0;
      scale    <= '0;
      pos      <= '0;
      asm_word <= '0;
      gathered <= '0;
    end else begin
      phase    <= phase_next;
      flag_cnt <= flag_cnt_next;
      scale    <= scale_next;
      pos      <= pos_next;
      asm_word <= asm_word_next;
      gathered <= gathered_next;
    end
  end
endmodule
`default_nettype wire

@@ src/vdp_back.sv @@
// Back: delta conversion, pipelined float/int accumulation, result register.
`default_nettype none
module vdp_back #(
  parameter int MAX_COMPONENTS = vdp_pkg::MAX_COMPONENTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         int_mode,
  input  wire logic         cmd_valid,
  output logic              cmd_pop,
  input  vdp_pkg::cmd_t     cmd,
  output logic              comp_valid,
  input  wire logic         comp_stall,
  output vdp_pkg::out_word_t comp_word
);
  logic [31:0] acc [MAX_COMPONENTS];

  // stage 0: converted delta
  logic        s0_v, s0_err, s0_last;
  logic [1:0]  s0_comp;
  logic [11:0] s0_entry;
  logic [31:0] s0_fval, s0_idelta;
  // stage 1: aligned operands
  logic        s1_v, s1_err, s1_last, s1_imode, s1_spec, s1_sx, s1_sub;
  logic [1:0]  s1_comp;
  logic [11:0] s1_entry;
  logic [31:0] s1_ires, s1_sbits;
  logic [7:0]  s1_ex;
  logic [26:0] s1_xa, s1_ya;
  // stage 2: raw sum
  logic        s2_v, s2_err, s2_last, s2_imode, s2_spec, s2_sgn;
  logic [1:0]  s2_comp;
  logic [11:0] s2_entry;
  logic [31:0] s2_ires, s2_sbits;
  logic [7:0]  s2_ex;
  logic [27:0] s2_m;
  logic [4:0]  s2_lz;

  logic en, haz, s0_take;

  // ---------------- conversion of the queue head ----------------
  logic [16:0] dv, mag17;
  logic [15:0] mag;
  logic        neg;
  logic [3:0]  msb;
  logic [8:0]  fexp;
  logic [23:0] norm;
  logic [31:0] fconv, fval, idelta;

  always_comb begin
    unique case (cmd.code)
      vdp_pkg::WC_BYTE: dv = {9'b0, cmd.raw[7:0]} - 17'(vdp_pkg::BIAS_BYTE);
      vdp_pkg::WC_HALF: dv = {1'b0, cmd.raw[15:0]} - 17'(vdp_pkg::BIAS_HALF);
      default:          dv = '0;
    endcase
    neg   = dv[16];
    mag17 = neg ? (17'd0 - dv) : dv;
    mag   = mag17[15:0];
    msb   = '0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) msb = 4'(i);
    end
    fexp  = 9'd127 + 9'(msb) - 9'(cmd.shift);
    norm  = 24'(mag) << (5'd23 - 5'(msb));
    fconv = (mag == '0) ? 32'd0 : {neg, fexp[7:0], norm[22:0]};
    unique case (cmd.code)
      vdp_pkg::WC_ZERO: begin fval = '0; idelta = '0; end
      vdp_pkg::WC_BYTE: begin fval = fconv; idelta = cmd.raw - vdp_pkg::BIAS_BYTE; end
      vdp_pkg::WC_HALF: begin fval = fconv; idelta = cmd.raw - vdp_pkg::BIAS_HALF; end
      default:          begin fval = cmd.raw; idelta = cmd.raw; end
    endcase
  end

  // ---------------- hazard and flow ----------------
  assign en = !comp_valid || !comp_stall;

  always_comb begin
    haz = 1'b0;
    if (s0_v && !s0_err) begin
      if (s1_v && !s1_err && (s1_comp == s0_comp || s1_last)) haz = 1'b1;
      if (s2_v && !s2_err && (s2_comp == s0_comp || s2_last)) haz = 1'b1;
    end
    s0_take = !s0_v || (en && !haz);
    cmd_pop = s0_take && cmd_valid;
  end

  // ---------------- stage 1 logic: unpack, specials, align ----------------
  logic [31:0] a, bv, x, y;
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [7:0]  exe, eye, d;
  logic [4:0]  sh;
  logic [23:0] sigx, sigy;
  logic [53:0] wide;
  logic [26:0] ya;
  logic        spec;
  logic [31:0] sbits;

  always_comb begin
    a = '0;
    for (int i = 0; i < MAX_COMPONENTS; i++) begin
      if (s0_comp == 2'(i)) a = acc[i];
    end
    bv    = s0_fval;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (bv[30:23] == 8'hFF) && (bv[22:0] != '0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf = (bv[30:23] == 8'hFF) && (bv[22:0] == '0);
    spec  = 1'b1;
    if (a_nan) sbits = a | vdp_pkg::QNAN_BIT;
    else if (b_nan) sbits = bv | vdp_pkg::QNAN_BIT;
    else if (a_inf && b_inf && (a[31] != bv[31])) sbits = vdp_pkg::DEFAULT_NAN;
    else if (a_inf) sbits = a;
    else if (b_inf) sbits = bv;
    else begin
      spec  = 1'b0;
      sbits = '0;
    end
    swap = (bv[30:0] > a[30:0]);
    x    = swap ? bv : a;
    y    = swap ? a : bv;
    exe  = (x[30:23] == '0) ? 8'd1 : x[30:23];
    eye  = (y[30:23] == '0) ? 8'd1 : y[30:23];
    sigx = {x[30:23] != '0, x[22:0]};
    sigy = {y[30:23] != '0, y[22:0]};
    d    = exe - eye;
    sh   = (d > 8'd27) ? 5'd27 : d[4:0];
    wide = {sigy, 3'b000, 27'b0} >> sh;
    ya   = wide[53:27];
    ya[0] = ya[0] | (|wide[26:0]);
  end

  // ---------------- stage 2 logic: add and leading zeros ----------------
  logic [27:0] sum;
  logic [4:0]  lz;

  always_comb begin
    if (s1_sub) sum = {1'b0, s1_xa} - {1'b0, s1_ya};
    else        sum = {1'b0, s1_xa} + {1'b0, s1_ya};
    lz = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (sum[i]) lz = 5'(27 - i);
    end
  end

  // ---------------- output stage logic: normalize and round ----------------
  logic [26:0] mn;
  logic [8:0]  e9, efield;
  logic [4:0]  k, k2;
  logic [7:0]  lim;
  logic        up;
  logic [24:0] sr;
  logic [22:0] frac;
  logic [31:0] fres, res;

  always_comb begin
    k   = s2_lz - 5'd1;
    lim = s2_ex - 8'd1;
    k2  = (8'(k) > lim) ? lim[4:0] : k;
    if (s2_m[27]) begin
      mn = s2_m[27:1];
      mn[0] = mn[0] | s2_m[0];
      e9 = 9'(s2_ex) + 9'd1;
    end else begin
      mn = s2_m[26:0] << k2;
      e9 = 9'(s2_ex) - 9'(k2);
    end
    up = mn[2] && (mn[3] || (|mn[1:0]));
    sr = {1'b0, mn[26:3]} + 25'(up);
    if (sr[24]) begin
      efield = e9 + 9'd1;
      frac   = sr[23:1];
    end else begin
      efield = sr[23] ? e9 : 9'd0;
      frac   = sr[22:0];
    end
    if (s2_m == '0) fres = {s2_sgn, 31'b0};
    else if (efield >= 9'd255) fres = {s2_sgn, 8'hFF, 23'b0};
    else fres = {s2_sgn, efield[7:0], frac};
    if (s2_err) res = '0;
    else if (s2_imode) res = s2_ires;
    else if (s2_spec) res = s2_sbits;
    else res = fres;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (s0_take) begin
      s0_err    <= cmd.err;
      s0_last   <= cmd.last;
      s0_comp   <= cmd.comp;
      s0_entry  <= cmd.entry;
      s0_fval   <= fval;
      s0_idelta <= idelta;
    end
    if (en) begin
      s1_err   <= s0_err;
      s1_last  <= s0_last;
      s1_comp  <= s0_comp;
      s1_entry <= s0_entry;
      s1_imode <= int_mode;
      s1_ires  <= a + s0_idelta + 32'd1;
      s1_spec  <= spec;
      s1_sbits <= sbits;
      s1_sx    <= x[31];
      s1_sub   <= x[31] ^ y[31];
      s1_ex    <= exe;
      s1_xa    <= {sigx, 3'b000};
      s1_ya    <= ya;
      s2_err   <= s1_err;
      s2_last  <= s1_last;
      s2_comp  <= s1_comp;
      s2_entry <= s1_entry;
      s2_imode <= s1_imode;
      s2_ires  <= s1_ires;
      s2_spec  <= s1_spec;
      s2_sbits <= s1_sbits;
      s2_sgn   <= ((sum == '0) && s1_sub) ? 1'b0 : s1_sx;
      s2_ex    <= s1_ex;
      s2_m     <= sum;
      s2_lz    <= lz;
      comp_word.value_bits  <= res;
      comp_word.component   <= s2_comp;
      comp_word.entry_index <= s2_entry;
      comp_word.last        <= s2_last;
      comp_word.order_error <= s2_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v       <= 1'b0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      comp_valid <= 1'b0;
      for (int i = 0; i < MAX_COMPONENTS; i++) acc[i] <= '0;
    end else begin
      if (s0_take) s0_v <= cmd_valid;
      if (en) begin
        s1_v       <= s0_v && !haz;
        s2_v       <= s1_v;
        comp_valid <= s2_v;
        if (s2_v && !s2_err) begin
          for (int i = 0; i < MAX_COMPONENTS; i++) begin
            if (s2_last) acc[i] <= '0;
            else if (s2_comp == 2'(i)) acc[i] <= res;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ src/vertex_delta_pack_decoder.sv @@
// Top level of the vertex delta pack decoder.
`default_nettype none
// Decodes one delta-packed geometry stream, one byte word per cycle. Program
// components_per_entry, entry_count and int_mode while idle, then send the
// flag bytes, the scale byte and the value bytes; a tick word (op=1) releases
// a component whose width code is zero. One result word comes out per
// finished component, with last set on the final one; the block then
// expects a new stream. A byte that arrives while a zero component waits is
// dropped and answered with an order_error word. Input is taken at one word
// per cycle while the command queue has room. From the finishing byte, a
// component passes the queue, convert, align, add and round registers to
// its result. The float adder is three stages deep and a component cannot
// enter it while the previous update of the same accumulator (or a stream
// end) is still in the align or add stage, so with three components per
// entry results flow every cycle while the output is not stalled, with one
// component per entry each waits for the previous one to leave the add
// stage. The flag store is a single-port-write, single-read memory of
// ceil(MAX_ENTRIES*MAX_COMPONENTS/4) bytes with no clearing pass after reset.
module vertex_delta_pack_decoder #(
  parameter int MAX_ENTRIES    = vdp_pkg::MAX_ENTRIES_DEF,
  parameter int MAX_COMPONENTS = vdp_pkg::MAX_COMPONENTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         byte_valid,
  output logic                              byte_stall,
  input  vdp_pkg::in_word_t                 byte_word,
  output logic                              comp_valid,
  input  wire logic                         comp_stall,
  output vdp_pkg::out_word_t                comp_word,
  input  wire logic                         cfg_we,
  input  wire logic [vdp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vdp_pkg::CFG_W-1:0]    cfg_wdata
);
  logic [vdp_pkg::CPE_W-1:0] cpe;
  logic [vdp_pkg::CNT_W-1:0] entry_count;
  logic                      int_mode;

  logic          q_push, q_full, q_pop, q_nonempty;
  vdp_pkg::cmd_t q_in, q_head;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cpe         <= vdp_pkg::CPE_W'(3);
      entry_count <= vdp_pkg::CNT_W'(1);
      int_mode    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vdp_pkg::CFG_CPE:      cpe         <= cfg_wdata[vdp_pkg::CPE_W-1:0];
        vdp_pkg::CFG_COUNT:    entry_count <= cfg_wdata[vdp_pkg::CNT_W-1:0];
        vdp_pkg::CFG_INT_MODE: int_mode    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  vdp_front #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .MAX_COMPONENTS(MAX_COMPONENTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .cpe        (cpe),
    .entry_count(entry_count),
    .cmd_push   (q_push),
    .cmd        (q_in),
    .cmd_full   (q_full)
  );

  vdp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .not_empty(q_nonempty)
  );

  vdp_back #(
    .MAX_COMPONENTS(MAX_COMPONENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .int_mode  (int_mode),
    .cmd_valid (q_nonempty),
    .cmd_pop   (q_pop),
    .cmd       (q_head),
    .comp_valid(comp_valid),
    .comp_stall(comp_stall),
    .comp_word (comp_word)
  );
endmodule
`default_nettype wire
